[hw/rtl/image_crop_flip_rescale_assert.svh]
// Assertion macros for the image crop, flip and rescale block.
// Used by the checker module; expects i_clk and i_rst_n in scope.
`ifndef IMAGE_CROP_FLIP_RESCALE_ASSERT_SVH
`define IMAGE_CROP_FLIP_RESCALE_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define ICFR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("icfr assertion failed");

// Consequent in the cycle after the antecedent.
`define ICFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("icfr assertion failed");

`endif

[hw/rtl/icfr_pkg.sv]
// Package for the image crop, flip and rescale block.
// Holds sizes, codes and shared types; depends on nothing else.
`default_nettype none
package icfr_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int W_DIM  = $clog2(MAX_WIDTH + 1);
    localparam int H_DIM  = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int PEND_W = W_DIM;
    localparam int ADDR_W = COL_W + 1;
    localparam int BUF_DEPTH = 2 ** ADDR_W;

    localparam int IN_WIDTH_W  = 11;
    localparam int IN_HEIGHT_W = 13;
    localparam int MODE_W      = 3;
    localparam int DRAW_W      = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;

    localparam int W_CMP = (W_DIM > IN_WIDTH_W) ? W_DIM : IN_WIDTH_W;
    localparam int H_CMP = (H_DIM > IN_HEIGHT_W) ? H_DIM : IN_HEIGHT_W;

    localparam int MODE_FLIP_BIT  = 0;
    localparam int MODE_NOADJ_BIT = 1;
    localparam int MODE_TRAIN_BIT = 2;

    localparam int DIV_N_W   = DRAW_W;
    localparam int DIV_D_W   = (W_DIM > H_DIM) ? W_DIM : H_DIM;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam int PIXEL_W = 16;
    localparam int VALUE_W = 17;
    localparam logic [VALUE_W-1:0] ADJ_OFFSET = 17'd65535;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_WIDTH   = 3'd0,
        CFG_IN_HEIGHT  = 3'd1,
        CFG_OUT_WIDTH  = 3'd2,
        CFG_OUT_HEIGHT = 3'd3,
        CFG_MODE_FLAGS = 3'd4,
        CFG_ROW_DRAW   = 3'd5,
        CFG_COL_DRAW   = 3'd6,
        CFG_FLIP_DRAW  = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        GEO_IDLE,
        GEO_CLAMP,
        GEO_START,
        GEO_DIV,
        GEO_FINISH
    } t_geo_state;

    typedef struct packed {
        logic [W_DIM-1:0] w;
        logic [H_DIM-1:0] h;
        logic [W_DIM-1:0] ow;
        logic [COL_W-1:0] col_first;
        logic [COL_W-1:0] col_last;
        logic [ROW_W-1:0] row_first;
        logic [ROW_W-1:0] row_last;
        logic             flip;
        logic             noadj;
    } t_geom;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [PIXEL_W-1:0] data;
    } t_buf_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_buf_rd;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_result;

endpackage
`default_nettype wire

[hw/rtl/icfr_in_if.sv]
// Input channel of the image crop, flip and rescale block.
// Carries the opcode and the pixel; uses icfr_pkg.
`default_nettype none
interface icfr_in_if;
    logic                            valid;
    logic                            ready;
    icfr_pkg::t_opcode               opcode;
    logic [icfr_pkg::PIXEL_W-1:0]    pixel;

    modport source (output valid, output opcode, output pixel, input ready);
    modport sink   (input valid, input opcode, input pixel, output ready);
endinterface
`default_nettype wire

[hw/rtl/icfr_out_if.sv]
// Output channel of the image crop, flip and rescale block.
// Carries the rescaled value and the end-of-plane mark; uses icfr_pkg.
`default_nettype none
interface icfr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [icfr_pkg::VALUE_W-1:0] value;
    logic                                last_in_plane;

    modport source (output valid, output value, output last_in_plane, input ready);
    modport sink   (input valid, input value, input last_in_plane, output ready);
endinterface
`default_nettype wire

[hw/rtl/image_crop_flip_rescale.sv]
// Top level of the image crop, flip and rescale block.
// Uses icfr_pkg, icfr_in_if, icfr_out_if, icfr_geom, icfr_row_buf and icfr_out_fifo.
//
// Each plane arrives on i_pix in raster order, one pixel per transaction with
// the pixel opcode. Pixels inside the crop window leave on o_res rescaled to
// 2p - 65535, or unchanged when the no-adjust flag is set; last_in_plane marks
// the final window sample of a plane. Flipped rows are written into one bank
// of the row store and, once a row is complete, leave reversed, one pixel per
// later pixel or drain transaction that carries no direct window sample.
// One transaction is accepted per cycle while i_pix is ready. A result passes
// through the read stage (the row store read or the registered pixel) and
// then the output queue before it appears on o_res. A configuration write
// stalls i_pix while the window is set up; the train-mode offsets come from
// bit-serial remainder units, each taking one draw bit per cycle.
// Reset clears the counters, the pending row and the output queue, and
// restores the default settings and window; the row store is not cleared. When the
// receiver stalls, up to three results wait in the output queue and i_pix
// drops ready once the queue and the read stage together hold three.
`default_nettype none
module image_crop_flip_rescale (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [icfr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [icfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    icfr_in_if.sink                               i_pix,
    icfr_out_if.source                            o_res
);
    icfr_pkg::t_geom                  geom;
    logic                             geo_busy;
    logic [icfr_pkg::FIFO_CNT_W-1:0]  fifo_count;
    logic [icfr_pkg::FIFO_CNT_W:0]    occupancy;

    logic [icfr_pkg::COL_W-1:0]   r_col;
    logic [icfr_pkg::ROW_W-1:0]   r_row;
    logic                         r_bank;
    logic [icfr_pkg::PEND_W-1:0]  r_pend;
    logic [icfr_pkg::COL_W-1:0]   r_rptr;
    logic                         r_plr;
    logic [icfr_pkg::COL_W-1:0]   n_col;
    logic [icfr_pkg::ROW_W-1:0]   n_row;
    logic                         n_bank;
    logic [icfr_pkg::PEND_W-1:0]  n_pend;
    logic [icfr_pkg::COL_W-1:0]   n_rptr;
    logic                         n_plr;

    logic                         acc;
    logic                         is_pixel;
    logic                         in_win;
    logic                         last_col;
    logic                         last_row;
    logic                         direct;
    logic                         rd_pend;
    logic                         wr_flip;
    logic [icfr_pkg::W_DIM-1:0]   col_inc;
    logic [icfr_pkg::H_DIM-1:0]   row_inc;

    icfr_pkg::t_buf_wr            buf_wr;
    icfr_pkg::t_buf_rd            buf_rd;
    logic [icfr_pkg::PIXEL_W-1:0] rd_data;

    logic                         r_s1_valid;
    logic                         r_s1_mem;
    logic                         r_s1_last;
    logic [icfr_pkg::PIXEL_W-1:0] r_s1_pixel;
    logic [icfr_pkg::PIXEL_W-1:0] s1_sample;
    icfr_pkg::t_result            s1_result;

    icfr_geom u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_geom     (geom),
        .o_busy     (geo_busy)
    );

    assign occupancy   = (icfr_pkg::FIFO_CNT_W + 1)'(fifo_count)
                       + (icfr_pkg::FIFO_CNT_W + 1)'(r_s1_valid);
    assign i_pix.ready = !geo_busy
                       && (occupancy < (icfr_pkg::FIFO_CNT_W + 1)'(icfr_pkg::FIFO_DEPTH));
    assign acc         = i_pix.valid && i_pix.ready;

    always_comb begin
        is_pixel = (i_pix.opcode == icfr_pkg::OP_PIXEL);
        in_win   = is_pixel
                && (r_row >= geom.row_first) && (r_row <= geom.row_last)
                && (r_col >= geom.col_first) && (r_col <= geom.col_last);
        last_col = in_win && (r_col == geom.col_last);
        last_row = in_win && (r_row == geom.row_last);
        direct   = in_win && !geom.flip;
        rd_pend  = !direct && (r_pend != '0);
        wr_flip  = in_win && geom.flip;
        col_inc  = icfr_pkg::W_DIM'(r_col) + icfr_pkg::W_DIM'(1);
        row_inc  = icfr_pkg::H_DIM'(r_row) + icfr_pkg::H_DIM'(1);
    end

    always_comb begin
        buf_wr.en   = acc && wr_flip;
        buf_wr.addr = {r_bank, r_col - geom.col_first};
        buf_wr.data = i_pix.pixel;
        buf_rd.en   = acc && rd_pend;
        buf_rd.addr = {~r_bank, r_rptr};
    end

    icfr_row_buf u_row_buf (
        .i_clk     (i_clk),
        .i_wr      (buf_wr),
        .i_rd      (buf_rd),
        .o_rd_data (rd_data)
    );

    // A completed flipped row replaces whatever is still pending.
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_bank = r_bank;
        n_pend = r_pend;
        n_rptr = r_rptr;
        n_plr  = r_plr;
        if (acc) begin
            if (rd_pend) begin
                n_pend = r_pend - icfr_pkg::PEND_W'(1);
                if (r_rptr != '0) begin
                    n_rptr = r_rptr - icfr_pkg::COL_W'(1);
                end
            end
            if (wr_flip && last_col) begin
                n_bank = ~r_bank;
                n_pend = icfr_pkg::PEND_W'(geom.ow);
                n_rptr = icfr_pkg::COL_W'(geom.ow - icfr_pkg::W_DIM'(1));
                n_plr  = last_row;
            end
            if (is_pixel) begin
                if (col_inc >= geom.w) begin
                    n_col = '0;
                    if (row_inc >= geom.h) begin
                        n_row = '0;
                    end else begin
                        n_row = icfr_pkg::ROW_W'(row_inc);
                    end
                end else begin
                    n_col = icfr_pkg::COL_W'(col_inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_bank     <= 1'b0;
            r_pend     <= '0;
            r_rptr     <= '0;
            r_plr      <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_bank     <= n_bank;
            r_pend     <= n_pend;
            r_rptr     <= n_rptr;
            r_plr      <= n_plr;
            r_s1_valid <= acc && (direct || rd_pend);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_mem   <= !direct;
            r_s1_pixel <= i_pix.pixel;
            if (direct) begin
                r_s1_last <= last_col && last_row;
            end else begin
                r_s1_last <= (r_pend == icfr_pkg::PEND_W'(1)) && r_plr;
            end
        end
    end

    always_comb begin
        s1_sample = r_s1_mem ? rd_data : r_s1_pixel;
        if (geom.noadj) begin
            s1_result.value = signed'({1'b0, s1_sample});
        end else begin
            s1_result.value = signed'({s1_sample, 1'b0} - icfr_pkg::ADJ_OFFSET);
        end
        s1_result.last = r_s1_last;
    end

    icfr_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (s1_result),
        .o_count (fifo_count),
        .o_res   (o_res)
    );
endmodule
`default_nettype wire

[hw/rtl/icfr_mod_unit.sv]
// Bit-serial remainder unit: one dividend bit per cycle.
// Used by icfr_geom for the crop offsets; uses icfr_pkg.
`default_nettype none
module icfr_mod_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [icfr_pkg::DIV_N_W-1:0]   i_num,
    input  wire logic [icfr_pkg::DIV_D_W-1:0]   i_den,
    output logic                                o_busy,
    output logic [icfr_pkg::DIV_D_W-1:0]        o_rem
);
    logic [icfr_pkg::DIV_N_W-1:0]   r_num;
    logic [icfr_pkg::DIV_D_W-1:0]   r_den;
    logic [icfr_pkg::DIV_D_W-1:0]   r_rem;
    logic [icfr_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic [icfr_pkg::DIV_D_W:0]     trial;
    logic [icfr_pkg::DIV_D_W:0]     diff;
    logic [icfr_pkg::DIV_D_W-1:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_num[icfr_pkg::DIV_N_W-1]};
        diff  = trial - {1'b0, r_den};
        if (trial >= {1'b0, r_den}) begin
            n_rem = diff[icfr_pkg::DIV_D_W-1:0];
        end else begin
            n_rem = trial[icfr_pkg::DIV_D_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= icfr_pkg::DIV_CNT_W'(icfr_pkg::DIV_N_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - icfr_pkg::DIV_CNT_W'(1);
            if (r_cnt == icfr_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[icfr_pkg::DIV_N_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

[hw/rtl/icfr_geom.sv]
// Configuration registers and crop window set-up of the block.
// Uses icfr_pkg and two icfr_mod_unit instances for the train-mode offsets.
`default_nettype none
module icfr_geom (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [icfr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [icfr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output icfr_pkg::t_geom                        o_geom,
    output logic                                   o_busy
);
    logic [icfr_pkg::IN_WIDTH_W-1:0]  r_in_width;
    logic [icfr_pkg::IN_HEIGHT_W-1:0] r_in_height;
    logic [icfr_pkg::IN_WIDTH_W-1:0]  r_out_width;
    logic [icfr_pkg::IN_HEIGHT_W-1:0] r_out_height;
    logic [icfr_pkg::MODE_W-1:0]      r_mode;
    logic [icfr_pkg::DRAW_W-1:0]      r_row_draw;
    logic [icfr_pkg::DRAW_W-1:0]      r_col_draw;
    logic                             r_flip_draw;

    icfr_pkg::t_geo_state r_state;
    icfr_pkg::t_geo_state n_state;
    logic                 busy;
    logic                 div_start;
    logic                 latch_clamp;
    logic                 latch_geom;

    logic [icfr_pkg::W_DIM-1:0] r_w;
    logic [icfr_pkg::H_DIM-1:0] r_h;
    logic [icfr_pkg::W_DIM-1:0] r_ow;
    logic [icfr_pkg::H_DIM-1:0] r_oh;
    logic [icfr_pkg::W_DIM-1:0] w_c;
    logic [icfr_pkg::H_DIM-1:0] h_c;
    logic [icfr_pkg::W_DIM-1:0] ow_c;
    logic [icfr_pkg::H_DIM-1:0] oh_c;
    logic [icfr_pkg::W_CMP-1:0] w_e;
    logic [icfr_pkg::W_CMP-1:0] ow_e;
    logic [icfr_pkg::H_CMP-1:0] h_e;
    logic [icfr_pkg::H_CMP-1:0] oh_e;

    logic [icfr_pkg::H_DIM-1:0]   slack_h;
    logic [icfr_pkg::W_DIM-1:0]   slack_w;
    logic [icfr_pkg::DIV_D_W-1:0] row_den;
    logic [icfr_pkg::DIV_D_W-1:0] col_den;
    logic [icfr_pkg::DIV_D_W-1:0] row_rem;
    logic [icfr_pkg::DIV_D_W-1:0] col_rem;
    logic                         row_busy;
    logic                         col_busy;

    logic                         train;
    logic                         flip;
    logic [icfr_pkg::ROW_W-1:0]   dh;
    logic [icfr_pkg::COL_W-1:0]   dw;
    logic [icfr_pkg::COL_W-1:0]   cs;
    icfr_pkg::t_geom              n_geom;
    icfr_pkg::t_geom              r_geom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width   <= icfr_pkg::IN_WIDTH_W'(1);
            r_in_height  <= icfr_pkg::IN_HEIGHT_W'(1);
            r_out_width  <= icfr_pkg::IN_WIDTH_W'(1);
            r_out_height <= icfr_pkg::IN_HEIGHT_W'(1);
            r_mode       <= '0;
            r_row_draw   <= '0;
            r_col_draw   <= '0;
            r_flip_draw  <= 1'b0;
        end else if (i_cfg_we) begin
            case (icfr_pkg::t_cfg_idx'(i_cfg_idx))
                icfr_pkg::CFG_IN_WIDTH: begin
                    r_in_width <= i_cfg_data[icfr_pkg::IN_WIDTH_W-1:0];
                end
                icfr_pkg::CFG_IN_HEIGHT: begin
                    r_in_height <= i_cfg_data[icfr_pkg::IN_HEIGHT_W-1:0];
                end
                icfr_pkg::CFG_OUT_WIDTH: begin
                    r_out_width <= i_cfg_data[icfr_pkg::IN_WIDTH_W-1:0];
                end
                icfr_pkg::CFG_OUT_HEIGHT: begin
                    r_out_height <= i_cfg_data[icfr_pkg::IN_HEIGHT_W-1:0];
                end
                icfr_pkg::CFG_MODE_FLAGS: begin
                    r_mode <= i_cfg_data[icfr_pkg::MODE_W-1:0];
                end
                icfr_pkg::CFG_ROW_DRAW: begin
                    r_row_draw <= i_cfg_data[icfr_pkg::DRAW_W-1:0];
                end
                icfr_pkg::CFG_COL_DRAW: begin
                    r_col_draw <= i_cfg_data[icfr_pkg::DRAW_W-1:0];
                end
                icfr_pkg::CFG_FLIP_DRAW: begin
                    r_flip_draw <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            icfr_pkg::GEO_IDLE:   n_state = icfr_pkg::GEO_IDLE;
            icfr_pkg::GEO_CLAMP:  n_state = icfr_pkg::GEO_START;
            icfr_pkg::GEO_START:  n_state = icfr_pkg::GEO_DIV;
            icfr_pkg::GEO_DIV: begin
                if (!row_busy && !col_busy) begin
                    n_state = icfr_pkg::GEO_FINISH;
                end
            end
            icfr_pkg::GEO_FINISH: n_state = icfr_pkg::GEO_IDLE;
            default:              n_state = icfr_pkg::GEO_IDLE;
        endcase
        if (i_cfg_we) begin
            n_state = icfr_pkg::GEO_CLAMP;
        end
    end

    always_comb begin
        busy        = 1'b1;
        div_start   = 1'b0;
        latch_clamp = 1'b0;
        latch_geom  = 1'b0;
        case (r_state)
            icfr_pkg::GEO_IDLE:   busy = 1'b0;
            icfr_pkg::GEO_CLAMP:  latch_clamp = 1'b1;
            icfr_pkg::GEO_START:  div_start = 1'b1;
            icfr_pkg::GEO_DIV:    busy = 1'b1;
            icfr_pkg::GEO_FINISH: latch_geom = 1'b1;
            default:              busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= icfr_pkg::GEO_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sizes of zero count as one; sizes beyond the limit saturate.
    always_comb begin
        w_e = icfr_pkg::W_CMP'(r_in_width);
        if (w_e == '0) begin
            w_c = icfr_pkg::W_DIM'(1);
        end else if (w_e > icfr_pkg::W_CMP'(icfr_pkg::MAX_WIDTH)) begin
            w_c = icfr_pkg::W_DIM'(icfr_pkg::MAX_WIDTH);
        end else begin
            w_c = icfr_pkg::W_DIM'(w_e);
        end
        ow_e = icfr_pkg::W_CMP'(r_out_width);
        if (ow_e == '0) begin
            ow_c = icfr_pkg::W_DIM'(1);
        end else if (ow_e > icfr_pkg::W_CMP'(w_c)) begin
            ow_c = w_c;
        end else begin
            ow_c = icfr_pkg::W_DIM'(ow_e);
        end
        h_e = icfr_pkg::H_CMP'(r_in_height);
        if (h_e == '0) begin
            h_c = icfr_pkg::H_DIM'(1);
        end else if (h_e > icfr_pkg::H_CMP'(icfr_pkg::MAX_HEIGHT)) begin
            h_c = icfr_pkg::H_DIM'(icfr_pkg::MAX_HEIGHT);
        end else begin
            h_c = icfr_pkg::H_DIM'(h_e);
        end
        oh_e = icfr_pkg::H_CMP'(r_out_height);
        if (oh_e == '0) begin
            oh_c = icfr_pkg::H_DIM'(1);
        end else if (oh_e > icfr_pkg::H_CMP'(h_c)) begin
            oh_c = h_c;
        end else begin
            oh_c = icfr_pkg::H_DIM'(oh_e);
        end
    end

    always_ff @(posedge i_clk) begin
        if (latch_clamp) begin
            r_w  <= w_c;
            r_h  <= h_c;
            r_ow <= ow_c;
            r_oh <= oh_c;
        end
    end

    assign slack_h = r_h - r_oh;
    assign slack_w = r_w - r_ow;
    assign row_den = icfr_pkg::DIV_D_W'(slack_h) + icfr_pkg::DIV_D_W'(1);
    assign col_den = icfr_pkg::DIV_D_W'(slack_w) + icfr_pkg::DIV_D_W'(1);

    icfr_mod_unit u_row_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_row_draw),
        .i_den   (row_den),
        .o_busy  (row_busy),
        .o_rem   (row_rem)
    );

    icfr_mod_unit u_col_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_col_draw),
        .i_den   (col_den),
        .o_busy  (col_busy),
        .o_rem   (col_rem)
    );

    always_comb begin
        train = r_mode[icfr_pkg::MODE_TRAIN_BIT];
        flip  = train && r_mode[icfr_pkg::MODE_FLIP_BIT] && r_flip_draw;
        if (train) begin
            dh = icfr_pkg::ROW_W'(row_rem);
            dw = icfr_pkg::COL_W'(col_rem);
        end else begin
            dh = icfr_pkg::ROW_W'(slack_h >> 1);
            dw = icfr_pkg::COL_W'(slack_w >> 1);
        end
        if (flip) begin
            cs = icfr_pkg::COL_W'(r_w - icfr_pkg::W_DIM'(dw) - r_ow);
        end else begin
            cs = dw;
        end
        n_geom.w         = r_w;
        n_geom.h         = r_h;
        n_geom.ow        = r_ow;
        n_geom.row_first = dh;
        n_geom.row_last  = icfr_pkg::ROW_W'(icfr_pkg::H_DIM'(dh) + r_oh
                                             - icfr_pkg::H_DIM'(1));
        n_geom.col_first = cs;
        n_geom.col_last  = icfr_pkg::COL_W'(icfr_pkg::W_DIM'(cs) + r_ow
                                             - icfr_pkg::W_DIM'(1));
        n_geom.flip      = flip;
        n_geom.noadj     = r_mode[icfr_pkg::MODE_NOADJ_BIT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.w         <= icfr_pkg::W_DIM'(1);
            r_geom.h         <= icfr_pkg::H_DIM'(1);
            r_geom.ow        <= icfr_pkg::W_DIM'(1);
            r_geom.row_first <= '0;
            r_geom.row_last  <= '0;
            r_geom.col_first <= '0;
            r_geom.col_last  <= '0;
            r_geom.flip      <= 1'b0;
            r_geom.noadj     <= 1'b0;
        end else if (latch_geom) begin
            r_geom <= n_geom;
        end
    end

    assign o_geom = r_geom;
    assign o_busy = busy;
endmodule
`default_nettype wire

[hw/rtl/icfr_row_buf.sv]
// Ping-pong row store for flipped rows: one write and one read port.
// Read data is registered and appears in the cycle after the read; uses icfr_pkg.
`default_nettype none
module icfr_row_buf (
    input  wire logic                          i_clk,
    input  wire icfr_pkg::t_buf_wr             i_wr,
    input  wire icfr_pkg::t_buf_rd             i_rd,
    output logic [icfr_pkg::PIXEL_W-1:0]       o_rd_data
);
    logic [icfr_pkg::PIXEL_W-1:0] r_mem [icfr_pkg::BUF_DEPTH];
    logic [icfr_pkg::PIXEL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

[hw/rtl/icfr_out_fifo.sv]
// Three-entry result queue that drives the output channel.
// Uses icfr_pkg and icfr_out_if.
`default_nettype none
module icfr_out_fifo (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    input  wire icfr_pkg::t_result                i_data,
    output logic [icfr_pkg::FIFO_CNT_W-1:0]       o_count,
    icfr_out_if.source                            o_res
);
    icfr_pkg::t_result                r_buf [icfr_pkg::FIFO_DEPTH];
    logic [icfr_pkg::FIFO_PTR_W-1:0]  r_wptr;
    logic [icfr_pkg::FIFO_PTR_W-1:0]  r_rptr;
    logic [icfr_pkg::FIFO_CNT_W-1:0]  r_count;
    logic                             pop;

    function automatic logic [icfr_pkg::FIFO_PTR_W-1:0] ptr_next(
        input logic [icfr_pkg::FIFO_PTR_W-1:0] p
    );
        if (p == icfr_pkg::FIFO_PTR_W'(icfr_pkg::FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + icfr_pkg::FIFO_PTR_W'(1);
    endfunction

    assign pop = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_next(r_wptr);
            end
            if (pop) begin
                r_rptr <= ptr_next(r_rptr);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + icfr_pkg::FIFO_CNT_W'(1);
                2'b01:   r_count <= r_count - icfr_pkg::FIFO_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

    assign o_count             = r_count;
    assign o_res.valid         = (r_count != '0);
    assign o_res.value         = r_buf[r_rptr].value;
    assign o_res.last_in_plane = r_buf[r_rptr].last;
endmodule
`default_nettype wire

[hw/rtl/icfr_checker.sv]
// Port-level checks for image_crop_flip_rescale, attached by a bind below.
// Uses icfr_in_if, icfr_out_if and the assertion macro header.
`default_nettype none
`include "image_crop_flip_rescale_assert.svh"
module icfr_checker (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    icfr_in_if.sink    i_pix,
    icfr_out_if.source o_res
);
    `ICFR_ASSERT_NOW(a_value_range, o_res.valid, o_res.value != 17'h10000)
    `ICFR_ASSERT_NEXT(a_cfg_stalls_input, i_cfg_we, !i_pix.ready)
    `ICFR_ASSERT_NOW(a_empty_after_reset, $rose(i_rst_n), !o_res.valid)
    `ICFR_ASSERT_NEXT(a_result_held, o_res.valid && !o_res.ready, o_res.valid && $stable(o_res.value) && $stable(o_res.last_in_plane))
endmodule

bind image_crop_flip_rescale icfr_checker u_icfr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_cfg_we (i_cfg_we),
    .i_pix    (i_pix),
    .o_res    (o_res)
);
`default_nettype wire

[test/icfr_crop_checker.sv]
// Checker for the image crop, flip and rescale block: it watches the register port and both
// channels, predicts every window sample and compares each result transaction with it.
// Depends on icfr_pkg, icfr_in_if and icfr_out_if.
module icfr_crop_checker
    import icfr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    icfr_in_if                         i_pix,
    icfr_out_if                        i_res,
    output int unsigned                o_fail_count,
    output int unsigned                o_outstanding,
    output int unsigned                o_checked
);

    typedef struct {
        int unsigned w;
        int unsigned h;
        int unsigned ow;
        int unsigned oh;
        int unsigned row0;
        int unsigned col0;
        bit          flip;
    } crop_window_t;

    logic [CFG_DATA_W-1:0] cfg_regs [8];
    logic [PIXEL_W-1:0]    line_store [BUF_DEPTH];
    logic [COL_W-1:0]      column_count;
    logic [ROW_W-1:0]      row_count;
    logic                  write_bank;
    logic [PEND_W-1:0]     pending_count;
    logic [COL_W-1:0]      read_pointer;
    logic                  pending_last_row;

    t_result     window_samples_due [$];
    int unsigned mismatches;
    int unsigned compared;

    function automatic logic [CFG_DATA_W-1:0] field_mask(input t_cfg_idx idx);
        case (idx)
            CFG_IN_WIDTH, CFG_OUT_WIDTH:   return 15'h07FF;
            CFG_IN_HEIGHT, CFG_OUT_HEIGHT: return 15'h1FFF;
            CFG_MODE_FLAGS:                return 15'h0007;
            CFG_FLIP_DRAW:                 return 15'h0001;
            default:                       return 15'h7FFF;
        endcase
    endfunction

    function automatic int unsigned fit_size(input int unsigned v, input int unsigned lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic crop_window_t window_now();
        crop_window_t      g;
        int unsigned       dw;
        logic [MODE_W-1:0] mode;
        bit                train;
        mode  = cfg_regs[CFG_MODE_FLAGS][MODE_W-1:0];
        train = mode[MODE_TRAIN_BIT];
        g.w  = fit_size(cfg_regs[CFG_IN_WIDTH], MAX_WIDTH);
        g.h  = fit_size(cfg_regs[CFG_IN_HEIGHT], MAX_HEIGHT);
        g.ow = fit_size(cfg_regs[CFG_OUT_WIDTH], g.w);
        g.oh = fit_size(cfg_regs[CFG_OUT_HEIGHT], g.h);
        if (train) begin
            g.row0 = cfg_regs[CFG_ROW_DRAW] % (g.h - g.oh + 1);
            dw     = cfg_regs[CFG_COL_DRAW] % (g.w - g.ow + 1);
        end else begin
            g.row0 = (g.h - g.oh) / 2;
            dw     = (g.w - g.ow) / 2;
        end
        g.flip = train && mode[MODE_FLIP_BIT] && cfg_regs[CFG_FLIP_DRAW][0];
        g.col0 = g.flip ? (g.w - dw - g.ow) : dw;
        return g;
    endfunction

    function automatic logic signed [VALUE_W-1:0] scale_sample(input logic [PIXEL_W-1:0] p);
        int v;
        if (cfg_regs[CFG_MODE_FLAGS][MODE_NOADJ_BIT]) begin
            v = int'(p);
        end else begin
            v = 2 * int'(p) - 65535;
        end
        return v[VALUE_W-1:0];
    endfunction

    // One accepted transaction: at most one sample becomes due, direct ones before pending ones.
    function automatic void advance_crop(input t_opcode op, input logic [PIXEL_W-1:0] px);
        crop_window_t     g;
        int unsigned      col;
        int unsigned      row;
        logic [COL_W-1:0] offset;
        bit               is_pixel;
        bit               in_win;
        bit               last_col;
        bit               last_row;
        t_result          r;
        g        = window_now();
        col      = column_count;
        row      = row_count;
        is_pixel = (op == OP_PIXEL);
        in_win   = is_pixel && row >= g.row0 && row < g.row0 + g.oh &&
                   col >= g.col0 && col < g.col0 + g.ow;
        last_col = in_win && col == g.col0 + g.ow - 1;
        last_row = in_win && row == g.row0 + g.oh - 1;

        if (in_win && !g.flip) begin
            r.value = scale_sample(px);
            r.last  = last_col && last_row;
            window_samples_due.push_back(r);
        end else if (pending_count != 0) begin
            r.value = scale_sample(line_store[{~write_bank, read_pointer}]);
            r.last  = (pending_count == 1) && pending_last_row;
            window_samples_due.push_back(r);
            pending_count--;
            if (read_pointer != 0) read_pointer--;
        end

        if (is_pixel) begin
            if (in_win && g.flip) begin
                offset = COL_W'(col - g.col0);
                line_store[{write_bank, offset}] = px;
                if (last_col) begin
                    write_bank       = ~write_bank;
                    pending_count    = PEND_W'(g.ow);
                    read_pointer     = COL_W'(g.ow - 1);
                    pending_last_row = last_row;
                end
            end
            col++;
            if (col >= g.w) begin
                col = 0;
                row++;
                if (row >= g.h) row = 0;
            end
            column_count = COL_W'(col);
            row_count    = ROW_W'(row);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result due;
        if (!i_rst_n) begin
            foreach (cfg_regs[i]) cfg_regs[i] = '0;
            cfg_regs[CFG_IN_WIDTH]   = CFG_DATA_W'(1);
            cfg_regs[CFG_IN_HEIGHT]  = CFG_DATA_W'(1);
            cfg_regs[CFG_OUT_WIDTH]  = CFG_DATA_W'(1);
            cfg_regs[CFG_OUT_HEIGHT] = CFG_DATA_W'(1);
            column_count     = '0;
            row_count        = '0;
            write_bank       = 1'b0;
            pending_count    = '0;
            read_pointer     = '0;
            pending_last_row = 1'b0;
            window_samples_due.delete();
            mismatches = 0;
            compared   = 0;
        end else begin
            if (i_cfg_we) begin
                cfg_regs[i_cfg_idx] = i_cfg_data & field_mask(t_cfg_idx'(i_cfg_idx));
            end
            if (i_res.valid && i_res.ready) begin
                if (window_samples_due.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("[%0t] unexpected result: value %0d last %0b", $time,
                                 i_res.value, i_res.last_in_plane);
                    end
                    mismatches++;
                end else begin
                    due = window_samples_due.pop_front();
                    compared++;
                    if (i_res.value !== due.value || i_res.last_in_plane !== due.last) begin
                        if (mismatches < 10) begin
                            $display("[%0t] result mismatch: value %0d (expected %0d), last %0b (expected %0b)",
                                     $time, i_res.value, due.value, i_res.last_in_plane,
                                     due.last);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                advance_crop(i_pix.opcode, i_pix.pixel);
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= window_samples_due.size();
        o_checked     <= compared;
    end

endmodule

[test/tb_image_crop_flip_rescale.sv]
// Testbench top for image_crop_flip_rescale: drives directed and random pixel streams under
// changing window settings, with bursty input and a stalling receiver, and gives the verdict.
// Depends on the RTL, icfr_pkg, icfr_in_if, icfr_out_if and icfr_crop_checker.
module tb_image_crop_flip_rescale;
    import icfr_pkg::*;

    localparam int unsigned FLAG_FLIP     = 1 << MODE_FLIP_BIT;
    localparam int unsigned FLAG_NOADJ    = 1 << MODE_NOADJ_BIT;
    localparam int unsigned FLAG_TRAIN    = 1 << MODE_TRAIN_BIT;
    localparam int unsigned RANDOM_ITEMS  = 1000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned LONG_HOLD     = 120;
    localparam int unsigned HOLD_ROW_W    = 48;

    typedef struct {
        int unsigned in_w;
        int unsigned in_h;
        int unsigned out_w;
        int unsigned out_h;
        int unsigned mode;
        int unsigned row_draw;
        int unsigned col_draw;
        int unsigned flip_draw;
    } setup_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned checked;
    int unsigned hold_requests = 0;

    setup_t      cur;
    int unsigned col_pos       = 0;
    int unsigned items_sent    = 0;
    int unsigned setups_loaded = 0;
    int unsigned burst_left    = 0;
    int unsigned idle_gap      = 0;

    icfr_in_if  pix ();
    icfr_out_if res ();

    image_crop_flip_rescale dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix),
        .o_res      (res)
    );

    icfr_crop_checker crop_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_pix         (pix),
        .i_res         (res),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [PIXEL_W-1:0] any_pixel();
        return PIXEL_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_item(input t_opcode op, input logic [PIXEL_W-1:0] px);
        int unsigned line_w;
        if (idle_gap != 0) begin
            pix.valid <= 1'b0;
            repeat (idle_gap) @(posedge i_clk);
            idle_gap = 0;
        end
        pix.valid  <= 1'b1;
        pix.opcode <= op;
        pix.pixel  <= px;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        items_sent++;
        line_w = (cur.in_w == 0) ? 1 : ((cur.in_w > MAX_WIDTH) ? MAX_WIDTH : cur.in_w);
        if (op == OP_PIXEL) begin
            col_pos++;
            if (col_pos >= line_w) col_pos = 0;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            idle_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
            burst_left--;
        end
    endtask

    task automatic settle();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_setup(input setup_t s);
        logic [CFG_DATA_W-1:0] vals [8];
        settle();
        vals[CFG_IN_WIDTH]   = CFG_DATA_W'(s.in_w);
        vals[CFG_IN_HEIGHT]  = CFG_DATA_W'(s.in_h);
        vals[CFG_OUT_WIDTH]  = CFG_DATA_W'(s.out_w);
        vals[CFG_OUT_HEIGHT] = CFG_DATA_W'(s.out_h);
        vals[CFG_MODE_FLAGS] = CFG_DATA_W'(s.mode);
        vals[CFG_ROW_DRAW]   = CFG_DATA_W'(s.row_draw);
        vals[CFG_COL_DRAW]   = CFG_DATA_W'(s.col_draw);
        vals[CFG_FLIP_DRAW]  = CFG_DATA_W'(s.flip_draw);
        cur = s;
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        setups_loaded++;
    endtask

    function automatic setup_t random_setup();
        setup_t      s;
        int unsigned w;
        int unsigned h;
        case ($urandom_range(0, 9))
            0:       s.in_w = 0;
            1:       s.in_w = 1;
            2:       s.in_w = $urandom_range(13, 40);
            default: s.in_w = $urandom_range(2, 12);
        endcase
        case ($urandom_range(0, 9))
            0:       s.in_h = 0;
            1:       s.in_h = 8191;
            2:       s.in_h = MAX_HEIGHT;
            default: s.in_h = $urandom_range(1, 6);
        endcase
        w = (s.in_w == 0) ? 1 : s.in_w;
        h = (s.in_h == 0) ? 1 : ((s.in_h > MAX_HEIGHT) ? MAX_HEIGHT : s.in_h);
        case ($urandom_range(0, 7))
            0:       s.out_w = 0;
            1:       s.out_w = 2047;
            default: s.out_w = $urandom_range(1, w + 1);
        endcase
        case ($urandom_range(0, 7))
            0:       s.out_h = 0;
            1:       s.out_h = 8191;
            default: s.out_h = $urandom_range(1, h + 1);
        endcase
        s.mode = $urandom_range(0, 7);
        if ($urandom_range(0, 1) != 0) s.mode = s.mode | FLAG_FLIP | FLAG_TRAIN;
        s.flip_draw = ($urandom_range(0, 3) != 0) ? 1 : 0;
        s.row_draw  = $urandom_range(0, 32767);
        s.col_draw  = $urandom_range(0, 32767);
        return s;
    endfunction

    initial begin : receiver
        int unsigned stretch;
        int unsigned stall_pct;
        int unsigned holds_served;
        holds_served = 0;
        res.ready <= 1'b0;
        forever begin
            stretch = $urandom_range(16, 160);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                2:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
            repeat (stretch) begin
                @(posedge i_clk);
                if (holds_served != hold_requests) begin
                    holds_served++;
                    res.ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge i_clk);
                end
                res.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin : stimulus
        setup_t      next;
        int unsigned random_items;
        int unsigned n;
        bit          next_flips;
        random_items = 0;
        cur = '{1, 1, 1, 1, 0, 0, 0, 0};
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_IN_WIDTH;
        i_cfg_data <= '0;
        pix.valid  <= 1'b0;
        pix.opcode <= OP_PIXEL;
        pix.pixel  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset window of one pixel, full-scale values, and a drain tick with nothing pending.
        send_item(OP_PIXEL, 16'd0);
        send_item(OP_PIXEL, 16'hFFFF);
        send_item(OP_DRAIN, 16'hFFFF);

        // Zero sizes count as one; values pass without adjustment.
        load_setup('{0, 0, 0, 0, FLAG_NOADJ, 0, 0, 0});
        send_item(OP_PIXEL, 16'hFFFF);
        send_item(OP_PIXEL, 16'd0);
        send_item(OP_DRAIN, 16'd0);

        // A window larger than the input is clipped, with the largest draws and a flip.
        load_setup('{3, 2, 2047, 8191, FLAG_FLIP | FLAG_NOADJ | FLAG_TRAIN, 32767, 32767, 1});
        repeat (6) send_item(OP_PIXEL, any_pixel());

        // Direct pixels leave ahead of the flipped row still pending.
        load_setup('{2, 1, 2, 1, FLAG_NOADJ, 0, 0, 0});
        repeat (2) send_item(OP_PIXEL, any_pixel());
        repeat (3) send_item(OP_DRAIN, any_pixel());

        // A narrower flipped row completes while the wider one is pending and drops the rest.
        load_setup('{4, 1, 4, 1, FLAG_FLIP | FLAG_TRAIN, 0, 0, 1});
        repeat (4) send_item(OP_PIXEL, any_pixel());
        load_setup('{2, 1, 2, 1, FLAG_FLIP | FLAG_TRAIN, 0, 0, 1});
        repeat (2) send_item(OP_PIXEL, any_pixel());
        repeat (2) send_item(OP_DRAIN, any_pixel());

        next = random_setup();
        while (random_items < RANDOM_ITEMS) begin
            load_setup(next);
            n = $urandom_range(1, 100);
            repeat (n) begin
                if ($urandom_range(0, 99) < 20) begin
                    send_item(OP_DRAIN, any_pixel());
                end else begin
                    send_item(OP_PIXEL, any_pixel());
                end
                random_items++;
            end
            next = random_setup();
            next_flips = ((next.mode & (FLAG_FLIP | FLAG_TRAIN)) == (FLAG_FLIP | FLAG_TRAIN)) &&
                         next.flip_draw != 0;
            // A flipped row must be written whole, so a flipped setting starts on a row boundary.
            if (next_flips || $urandom_range(0, 2) != 0) begin
                while (col_pos != 0) begin
                    send_item(OP_PIXEL, any_pixel());
                    random_items++;
                end
            end
        end
        while (col_pos != 0) send_item(OP_PIXEL, any_pixel());

        // Whole-width flipped rows; the receiver holds off while the second row streams in.
        load_setup('{HOLD_ROW_W, 2, HOLD_ROW_W, 2, FLAG_FLIP | FLAG_TRAIN,
                     $urandom_range(0, 32767), $urandom_range(0, 32767), 1});
        repeat (HOLD_ROW_W) send_item(OP_PIXEL, any_pixel());
        hold_requests <= hold_requests + 1;
        repeat (HOLD_ROW_W) send_item(OP_PIXEL, any_pixel());
        repeat (HOLD_ROW_W) send_item(OP_DRAIN, any_pixel());

        settle();
        $display("Run covered %0d transactions under %0d register settings; %0d results compared.",
                 items_sent, setups_loaded + 1, checked);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
